// ----- hdl/pmvs_pkg.sv -----
// ----------------------------------------------------------------------------
// pmvs_pkg
// shared types, constants and field layouts of the per-slot statistics block
// ----------------------------------------------------------------------------
package pmvs_pkg;

   // defaults of the top level parameters
   localparam int SLOT_COUNT_DEF  = 1024;
   localparam int SAMPLE_BITS_DEF = 24;

   // field widths
   localparam int SLOT_W   = 10;
   localparam int SAMPLE_W = 24;
   localparam int RUN_W    = 11;
   localparam int MPG_W    = 6;
   localparam int SUM_W    = 34;
   localparam int SQ_W     = 58;

   // request codes
   localparam logic [1:0] REQ_ADD    = 2'd0;
   localparam logic [1:0] REQ_REPORT = 2'd1;
   localparam logic [1:0] REQ_CLEAR  = 2'd2;

   // register indexes
   localparam int          CSR_INDEX_W   = 1;
   localparam int          CSR_DATA_W    = 11;
   localparam logic [0:0]  CSR_RUN_COUNT = 1'd0;
   localparam logic [0:0]  CSR_MEMBERS   = 1'd1;

   // iterative unit widths
   localparam int DIV_DW  = 85;
   localparam int DIV_VW  = 40;
   localparam int MUL_AW  = 58;
   localparam int MUL_BW  = 34;
   localparam int MUL_PW  = MUL_AW + MUL_BW;
   localparam int SQRT_XW = 80;
   localparam int SQRT_RW = 40;

   typedef struct packed {
      logic [1:0]          req_type;
      logic [SLOT_W-1:0]   slot;
      logic [SAMPLE_W-1:0] sample;
   } pmvs_req_type;

   typedef struct packed {
      logic [9:0]  group_index;
      logic [4:0]  member_index;
      logic [39:0] mean_q16;
      logic [62:0] variance_q16;
      logic [38:0] stddev_q16;
      logic [21:0] cv_q16;
      logic [23:0] min_sample;
      logic [23:0] max_sample;
   } pmvs_rsp_type;

   typedef struct packed {
      logic [SUM_W-1:0]    sum;
      logic [SQ_W-1:0]     square_sum;
      logic [SAMPLE_W-1:0] min_sample;
      logic [SAMPLE_W-1:0] max_sample;
   } pmvs_entry_type;

   localparam pmvs_entry_type ENTRY_EMPTY = '{
      sum:        '0,
      square_sum: '0,
      min_sample: '1,
      max_sample: '0
   };

endpackage

// ----- hdl/per_slot_mean_variance_stats.sv -----
// ----------------------------------------------------------------------------
// per_slot_mean_variance_stats
// per-slot sum, sum of squares, min and max with mean / variance reports
// ----------------------------------------------------------------------------
// Each slot keeps its running sum, sum of squares, minimum and maximum in one
// synchronous memory entry. For a sample or clear transfer the entry is read
// on the accepting edge and written back on the next, so back-to-back samples
// to the same slot never overlap. A report runs four divisions on one
// restoring divider (mean, variance, coefficient of variation, group/member
// split), two products on one shift-add multiplier and a square root, between
// a load state and an output state. With a zero mean the cv division is
// skipped. Samples, clears and unknown requests give no response; a report
// response sits in an output register so the next request can be taken while
// it waits. After reset the memory is swept clean, one slot per cycle, and no
// request is accepted until it ends; register writes are taken at any time.
// ----------------------------------------------------------------------------
module per_slot_mean_variance_stats
   import pmvs_pkg::*;
#(
   parameter int SLOT_COUNT  = SLOT_COUNT_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  pmvs_req_type           req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output pmvs_rsp_type           rsp_data,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX =
      SAMPLE_W'((25'd1 << SAMPLE_BITS) - 25'd1);

   typedef enum logic [3:0] {
      S_IDLE, S_WR, S_LOAD, S_MEAN, S_MULA, S_MULB,
      S_VAR, S_SQRT, S_CV, S_GRP, S_OUT
   } state_type;

   state_type             state_ff;
   logic                  started_ff;

   // configuration
   logic [RUN_W-1:0]      run_count_ff;
   logic [MPG_W-1:0]      members_ff;
   logic [RUN_W-1:0]      n_eff;
   logic [MPG_W-1:0]      m_eff;
   logic [21:0]           n_sq;

   // request held for the write-back / report
   logic [1:0]            type_ff;
   logic [SLOT_W-1:0]     slot_ff;
   logic                  valid_ff;
   logic [SAMPLE_W-1:0]   sample_ff;
   logic [2*SAMPLE_W-1:0] s2_ff;
   logic [SAMPLE_W-1:0]   sample_sat;

   // report operands and partial results
   logic [SUM_W-1:0]      sum_ff;
   logic [SQ_W-1:0]       sq_ff;
   logic [SAMPLE_W-1:0]   min_ff;
   logic [SAMPLE_W-1:0]   max_ff;
   logic [39:0]           mean_ff;
   logic [68:0]           proda_ff;
   logic [68:0]           d_ff;
   logic [62:0]           var_ff;
   logic [38:0]           sd_ff;
   logic [21:0]           cv_ff;

   pmvs_rsp_type          rsp_data_ff;
   logic                  rsp_valid_ff;

   // store
   logic                  req_accept;
   logic                  clr_busy;
   pmvs_entry_type        rd_data;
   pmvs_entry_type        wr_data;
   logic                  wr_en;
   logic [SUM_W:0]        sum_add;
   logic [SQ_W:0]         sq_add;

   // shared units
   logic                  div_start, div_busy, div_done;
   logic [DIV_DW-1:0]     div_dividend, div_quo;
   logic [DIV_VW-1:0]     div_divisor, div_rem;
   logic                  mul_start, mul_busy, mul_done;
   logic [MUL_AW-1:0]     mul_a;
   logic [MUL_BW-1:0]     mul_b;
   logic [MUL_PW-1:0]     mul_prod;
   logic                  sqrt_start, sqrt_busy, sqrt_done;
   logic [SQRT_RW-1:0]    sqrt_root;

   assign req_stall  = (state_ff != S_IDLE) || clr_busy;
   assign req_accept = req_valid && !req_stall;

   // zero run count reads as one; members clamp to 1..32
   assign n_eff = (run_count_ff == '0) ? RUN_W'(1) : run_count_ff;
   always_comb begin
      if (members_ff == '0) begin
         m_eff = MPG_W'(1);
      end else if (members_ff > MPG_W'(32)) begin
         m_eff = MPG_W'(32);
      end else begin
         m_eff = members_ff;
      end
   end
   assign n_sq = 22'(n_eff) * 22'(n_eff);

   assign sample_sat = (req_data.sample > SAMPLE_MAX) ? SAMPLE_MAX : req_data.sample;

   // sample fold-in, saturating sums
   assign sum_add = (SUM_W+1)'(rd_data.sum) + (SUM_W+1)'(sample_ff);
   assign sq_add  = (SQ_W+1)'(rd_data.square_sum) + (SQ_W+1)'(s2_ff);
   always_comb begin
      wr_data = ENTRY_EMPTY;
      if (type_ff == REQ_ADD) begin
         wr_data.sum        = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
         wr_data.square_sum = sq_add[SQ_W] ? '1 : sq_add[SQ_W-1:0];
         wr_data.min_sample = (sample_ff < rd_data.min_sample) ? sample_ff
                                                               : rd_data.min_sample;
         wr_data.max_sample = (sample_ff > rd_data.max_sample) ? sample_ff
                                                               : rd_data.max_sample;
      end
   end
   assign wr_en = (state_ff == S_WR) && valid_ff;

   pmvs_store #(
      .SLOT_COUNT (SLOT_COUNT),
      .AW         (AW)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (req_accept),
      .rd_addr  (AW'(req_data.slot)),
      .rd_data  (rd_data),
      .wr_en    (wr_en),
      .wr_addr  (AW'(slot_ff)),
      .wr_data  (wr_data),
      .clr_busy (clr_busy)
   );

   // operand selection for the shared units
   always_comb begin
      div_dividend = {{(DIV_DW-SLOT_W){1'b0}}, slot_ff};
      div_divisor  = DIV_VW'(m_eff);
      unique case (state_ff)
         S_MEAN: begin
            div_dividend = {{(DIV_DW-SUM_W-16){1'b0}}, sum_ff, 16'd0};
            div_divisor  = DIV_VW'(n_eff);
         end
         S_VAR: begin
            div_dividend = {d_ff, 16'd0};
            div_divisor  = DIV_VW'(n_sq);
         end
         S_CV: begin
            div_dividend = {{(DIV_DW-39-16){1'b0}}, sd_ff, 16'd0};
            div_divisor  = mean_ff;
         end
         default: begin
            div_dividend = {{(DIV_DW-SLOT_W){1'b0}}, slot_ff};
            div_divisor  = DIV_VW'(m_eff);
         end
      endcase
   end

   assign div_start = !started_ff &&
      ((state_ff == S_MEAN) || (state_ff == S_VAR) || (state_ff == S_GRP) ||
       ((state_ff == S_CV) && (mean_ff != '0)));
   assign mul_start  = !started_ff && ((state_ff == S_MULA) || (state_ff == S_MULB));
   assign sqrt_start = !started_ff && (state_ff == S_SQRT);

   // n * sumsq first, then sum * sum
   assign mul_a = (state_ff == S_MULA) ? sq_ff : MUL_AW'(sum_ff);
   assign mul_b = (state_ff == S_MULA) ? MUL_BW'(n_eff) : sum_ff;

   pmvs_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .busy      (div_busy),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   pmvs_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .busy    (mul_busy),
      .done    (mul_done),
      .product (mul_prod)
   );

   pmvs_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand ({1'b0, var_ff, 16'd0}),
      .busy     (sqrt_busy),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         run_count_ff <= RUN_W'(1);
         members_ff   <= MPG_W'(32);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_RUN_COUNT: run_count_ff <= csr_wdata;
            CSR_MEMBERS:   members_ff   <= csr_wdata[MPG_W-1:0];
            default:       ;
         endcase
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         started_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // the output state refills the register itself
         if (rsp_valid_ff && !rsp_stall && (state_ff != S_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         if (div_start || mul_start || sqrt_start) begin
            started_ff <= 1'b1;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_accept) begin
                  priority case (req_data.req_type)
                     REQ_ADD, REQ_CLEAR: state_ff <= S_WR;
                     REQ_REPORT:         state_ff <= S_LOAD;
                     default:            state_ff <= S_IDLE;
                  endcase
               end
            end
            S_WR: state_ff <= S_IDLE;
            S_LOAD: begin
               state_ff   <= S_MEAN;
               started_ff <= 1'b0;
            end
            S_MEAN: begin
               if (div_done) begin
                  state_ff   <= S_MULA;
                  started_ff <= 1'b0;
               end
            end
            S_MULA: begin
               if (mul_done) begin
                  state_ff   <= S_MULB;
                  started_ff <= 1'b0;
               end
            end
            S_MULB: begin
               if (mul_done) begin
                  state_ff   <= S_VAR;
                  started_ff <= 1'b0;
               end
            end
            S_VAR: begin
               if (div_done) begin
                  state_ff   <= S_SQRT;
                  started_ff <= 1'b0;
               end
            end
            S_SQRT: begin
               if (sqrt_done) begin
                  state_ff   <= S_CV;
                  started_ff <= 1'b0;
               end
            end
            S_CV: begin
               // zero mean gives zero cv without a division
               if (mean_ff == '0 || div_done) begin
                  state_ff   <= S_GRP;
                  started_ff <= 1'b0;
               end
            end
            S_GRP: begin
               if (div_done) begin
                  state_ff   <= S_OUT;
                  started_ff <= 1'b0;
               end
            end
            S_OUT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         type_ff   <= req_data.req_type;
         slot_ff   <= req_data.slot;
         valid_ff  <= 32'(req_data.slot) < SLOT_COUNT;
         sample_ff <= sample_sat;
         s2_ff     <= sample_sat * sample_sat;
      end
      if (state_ff == S_LOAD) begin
         // slot beyond the store reads as an empty slot
         sum_ff <= valid_ff ? rd_data.sum        : ENTRY_EMPTY.sum;
         sq_ff  <= valid_ff ? rd_data.square_sum : ENTRY_EMPTY.square_sum;
         min_ff <= valid_ff ? rd_data.min_sample : ENTRY_EMPTY.min_sample;
         max_ff <= valid_ff ? rd_data.max_sample : ENTRY_EMPTY.max_sample;
      end
      if (state_ff == S_MEAN && div_done) begin
         mean_ff <= (|div_quo[DIV_DW-1:40]) ? '1 : div_quo[39:0];
      end
      if (state_ff == S_MULA && mul_done) begin
         proda_ff <= mul_prod[68:0];
      end
      if (state_ff == S_MULB && mul_done) begin
         // numerator clamps at zero
         d_ff <= (proda_ff >= mul_prod[68:0]) ? proda_ff - mul_prod[68:0] : '0;
      end
      if (state_ff == S_VAR && div_done) begin
         var_ff <= (|div_quo[DIV_DW-1:63]) ? '1 : div_quo[62:0];
      end
      if (state_ff == S_SQRT && sqrt_done) begin
         sd_ff <= sqrt_root[SQRT_RW-1] ? '1 : sqrt_root[38:0];
      end
      if (state_ff == S_CV) begin
         if (mean_ff == '0) begin
            cv_ff <= '0;
         end else if (div_done) begin
            cv_ff <= (|div_quo[DIV_DW-1:22]) ? '1 : div_quo[21:0];
         end
      end
      if (state_ff == S_OUT && (!rsp_valid_ff || !rsp_stall)) begin
         rsp_data_ff.group_index  <= div_quo[9:0];
         rsp_data_ff.member_index <= div_rem[4:0];
         rsp_data_ff.mean_q16     <= mean_ff;
         rsp_data_ff.variance_q16 <= var_ff;
         rsp_data_ff.stddev_q16   <= sd_ff;
         rsp_data_ff.cv_q16       <= cv_ff;
         rsp_data_ff.min_sample   <= min_ff;
         rsp_data_ff.max_sample   <= max_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   // no request transfer while the store is being swept
   assert property (@(posedge clock) disable iff (reset) clr_busy |-> req_stall)
      else $error("request taken during clearing sweep");

   // a unit is never restarted while it runs
   assert property (@(posedge clock) disable iff (reset)
      !((div_start && div_busy) || (mul_start && mul_busy) || (sqrt_start && sqrt_busy)))
      else $error("iterative unit restarted while busy");

   // an in-range sample transfer is written back on the next edge
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_data.req_type == REQ_ADD && 32'(req_data.slot) < SLOT_COUNT)
      |=> wr_en)
      else $error("sample not written back");

   // a response appears only out of the output state
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_OUT))
      else $error("response raised outside output state");
`endif

endmodule

// ----- hdl/pmvs_store.sv -----
// ----------------------------------------------------------------------------
// pmvs_store
// slot memory, one write and one registered read port, cleared after reset
// ----------------------------------------------------------------------------
module pmvs_store
   import pmvs_pkg::*;
#(
   parameter int SLOT_COUNT = SLOT_COUNT_DEF,
   parameter int AW         = 10
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           rd_en,
   input  logic [AW-1:0]  rd_addr,
   output pmvs_entry_type rd_data,
   input  logic           wr_en,
   input  logic [AW-1:0]  wr_addr,
   input  pmvs_entry_type wr_data,
   output logic           clr_busy
);

   localparam logic [AW-1:0] LAST = AW'(SLOT_COUNT - 1);

   pmvs_entry_type mem [SLOT_COUNT];
   pmvs_entry_type rd_data_ff;
   logic           clr_busy_ff;
   logic [AW-1:0]  clr_addr_ff;

   // clearing sweep, one entry a cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         if (clr_addr_ff == LAST) begin
            clr_busy_ff <= 1'b0;
         end
         clr_addr_ff <= clr_addr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         mem[clr_addr_ff] <= ENTRY_EMPTY;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data  = rd_data_ff;
   assign clr_busy = clr_busy_ff;

endmodule

// ----- hdl/pmvs_div.sv -----
// ----------------------------------------------------------------------------
// pmvs_div
// restoring divider, one quotient bit a cycle
// ----------------------------------------------------------------------------
module pmvs_div
   import pmvs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIV_DW-1:0] dividend,
   input  logic [DIV_VW-1:0] divisor,
   output logic              busy,
   output logic              done,
   output logic [DIV_DW-1:0] quotient,
   output logic [DIV_VW-1:0] remainder
);

   localparam int CW = $clog2(DIV_DW);

   logic              busy_ff;
   logic              done_ff;
   logic [CW-1:0]     cnt_ff;
   logic [DIV_DW-1:0] quo_ff;
   logic [DIV_VW-1:0] rem_ff;
   logic [DIV_VW-1:0] dvs_ff;
   logic [DIV_VW:0]   trial;
   logic              ge;
   logic [DIV_VW-1:0] rem_in;

   assign trial  = {rem_ff, quo_ff[DIV_DW-1]};
   assign ge     = trial >= {1'b0, dvs_ff};
   assign rem_in = ge ? DIV_VW'(trial - {1'b0, dvs_ff}) : trial[DIV_VW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(DIV_DW - 1);
         end else if (busy_ff) begin
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[DIV_DW-2:0], ge};
         rem_ff <= rem_in;
      end
   end

   assign busy      = busy_ff;
   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ----- hdl/pmvs_mul.sv -----
// ----------------------------------------------------------------------------
// pmvs_mul
// shift-and-add multiplier, one multiplier bit a cycle
// ----------------------------------------------------------------------------
module pmvs_mul
   import pmvs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [MUL_AW-1:0] op_a,
   input  logic [MUL_BW-1:0] op_b,
   output logic              busy,
   output logic              done,
   output logic [MUL_PW-1:0] product
);

   localparam int CW = $clog2(MUL_BW);

   logic              busy_ff;
   logic              done_ff;
   logic [CW-1:0]     cnt_ff;
   logic [MUL_PW-1:0] acc_ff;
   logic [MUL_PW-1:0] mcand_ff;
   logic [MUL_BW-1:0] mplier_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(MUL_BW - 1);
         end else if (busy_ff) begin
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         acc_ff    <= '0;
         mcand_ff  <= MUL_PW'(op_a);
         mplier_ff <= op_b;
      end else if (busy_ff) begin
         if (mplier_ff[0]) begin
            acc_ff <= acc_ff + mcand_ff;
         end
         mcand_ff  <= {mcand_ff[MUL_PW-2:0], 1'b0};
         mplier_ff <= {1'b0, mplier_ff[MUL_BW-1:1]};
      end
   end

   assign busy    = busy_ff;
   assign done    = done_ff;
   assign product = acc_ff;

endmodule

// ----- hdl/pmvs_sqrt.sv -----
// ----------------------------------------------------------------------------
// pmvs_sqrt
// digit-by-digit integer square root, one root bit a cycle
// ----------------------------------------------------------------------------
module pmvs_sqrt
   import pmvs_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [SQRT_XW-1:0] radicand,
   output logic               busy,
   output logic               done,
   output logic [SQRT_RW-1:0] root
);

   localparam int CW = $clog2(SQRT_RW);
   localparam int EW = SQRT_RW + 2;

   logic               busy_ff;
   logic               done_ff;
   logic [CW-1:0]      cnt_ff;
   logic [SQRT_XW-1:0] x_ff;
   logic [EW-1:0]      rem_ff;
   logic [SQRT_RW-1:0] root_ff;
   logic [EW-1:0]      trial;
   logic [EW-1:0]      cand;
   logic               ge;

   assign trial = {rem_ff[SQRT_RW-1:0], x_ff[SQRT_XW-1 -: 2]};
   assign cand  = {root_ff, 2'b01};
   assign ge    = trial >= cand;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(SQRT_RW - 1);
         end else if (busy_ff) begin
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         x_ff    <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         x_ff    <= {x_ff[SQRT_XW-3:0], 2'b00};
         rem_ff  <= ge ? trial - cand : trial;
         root_ff <= {root_ff[SQRT_RW-2:0], ge};
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign root = root_ff;

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the per-slot mean / variance statistics block
// ----------------------------------------------------------------------------
// A short directed table comes first: empty slots after reset, the largest
// sample, a zero sample, an unknown request, a variance numerator that clamps
// at zero, and a clear. Random phases follow. Each phase writes both
// registers, including zero and out-of-range values, and uses one of four
// sender / receiver idling patterns. Every report is checked field by field
// against the table's expected values or an in-bench model of the slot store.
// ----------------------------------------------------------------------------
module testbench;
   import pmvs_pkg::*;

   localparam int SLOTS = 1024;
   localparam int DRAIN = 600;

   // request code with no meaning, dropped by the block
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   pmvs_req_type           req_data;
   logic                   rsp_valid;
   logic                   rsp_stall;
   pmvs_rsp_type           rsp_data;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   per_slot_mean_variance_stats dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // idling patterns
   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   typedef struct {
      logic [1:0]   kind;
      int           slot;
      int           smp;
      bit           typed;
      pmvs_rsp_type rsp;
   } stim_row_type;

   // model of the slot store and registers
   logic [SUM_W-1:0]    stat_sum [SLOTS];
   logic [SQ_W-1:0]     stat_sq  [SLOTS];
   logic [SAMPLE_W-1:0] stat_min [SLOTS];
   logic [SAMPLE_W-1:0] stat_max [SLOTS];
   logic [RUN_W-1:0]    run_count;
   logic [MPG_W-1:0]    members;

   pmvs_rsp_type  pending_reports[$];
   stim_row_type  directed[$];
   idle_mode_type idle_mode;
   int            mismatches = 0;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // watchdog
   initial begin
      #20_000_000;
      $display("tb: failure");
      $finish;
   end

   task automatic note_mismatch(input string field, input logic [63:0] want,
                                input logic [63:0] got);
      $display("mismatch %s: expected %0h got %0h at %0t", field, want, got, $time);
      mismatches++;
   endtask

   function automatic pmvs_rsp_type slot_report(input int s);
      pmvs_rsp_type r;
      logic [127:0] n, m, mean, a, b, d, q, var_w, x, c, sd, cv;
      n = (run_count == 0) ? 1 : run_count;
      m = (members == 0) ? 1 : (members > 32) ? 32 : members;
      mean = {stat_sum[s], 16'd0} / n;
      if (mean > 40'hFF_FFFF_FFFF) mean = 40'hFF_FFFF_FFFF;
      a = n * stat_sq[s];
      b = stat_sum[s] * stat_sum[s];
      d = (a < b) ? 0 : a - b;
      q = (d << 16) / (n * n);
      var_w = (q > 64'h7FFF_FFFF_FFFF_FFFF) ? 64'h7FFF_FFFF_FFFF_FFFF : q;
      // floor square root, one bit per step from the top
      x = var_w << 16;
      sd = 0;
      for (int i = 39; i >= 0; i--) begin
         c = sd | (128'd1 << i);
         if (c * c <= x) sd = c;
      end
      if (sd > 39'h7F_FFFF_FFFF) sd = 39'h7F_FFFF_FFFF;
      if (mean == 0) cv = 0;
      else begin
         cv = (sd << 16) / mean;
         if (cv > 22'h3F_FFFF) cv = 22'h3F_FFFF;
      end
      r.group_index  = s / m;
      r.member_index = s % m;
      r.mean_q16     = mean[39:0];
      r.variance_q16 = var_w[62:0];
      r.stddev_q16   = sd[38:0];
      r.cv_q16       = cv[21:0];
      r.min_sample   = stat_min[s];
      r.max_sample   = stat_max[s];
      return r;
   endfunction

   // fold one accepted transfer into the store model
   task automatic apply_request(input pmvs_req_type r, input bit typed,
                                input pmvs_rsp_type typed_rsp);
      logic [63:0] s2, nsum, nsq;
      s2 = r.sample * r.sample;
      case (r.req_type)
         REQ_ADD: begin
            nsum = stat_sum[r.slot] + r.sample;
            nsq  = stat_sq[r.slot] + s2;
            stat_sum[r.slot] = (nsum > {SUM_W{1'b1}}) ? '1 : nsum[SUM_W-1:0];
            stat_sq[r.slot]  = (nsq > {SQ_W{1'b1}}) ? '1 : nsq[SQ_W-1:0];
            if (r.sample < stat_min[r.slot]) stat_min[r.slot] = r.sample;
            if (r.sample > stat_max[r.slot]) stat_max[r.slot] = r.sample;
         end
         REQ_CLEAR: begin
            stat_sum[r.slot] = '0;
            stat_sq[r.slot]  = '0;
            stat_min[r.slot] = '1;
            stat_max[r.slot] = '0;
         end
         REQ_REPORT: begin
            pending_reports.insert(pending_reports.size(),
                                   typed ? typed_rsp : slot_report(r.slot));
         end
         default: ;   // unknown request is dropped
      endcase
   endtask

   // one transfer on the request channel, with idle gaps per phase
   task automatic send_request(input logic [1:0] kind, input int s, input int smp,
                               input bit typed, input pmvs_rsp_type typed_rsp);
      pmvs_req_type r;
      r.req_type = kind;
      r.slot     = s[SLOT_W-1:0];
      r.sample   = smp[SAMPLE_W-1:0];
      if (idle_mode == IDLE_SENDER || idle_mode == IDLE_BOTH) begin
         while ($urandom_range(99) < ((idle_mode == IDLE_SENDER) ? 72 : 12)) begin
            @(negedge clock);
            req_valid <= 1'b0;
         end
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= r;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      apply_request(r, typed, typed_rsp);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input int value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_DATA_W-1:0];
      @(negedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_RUN_COUNT) run_count = value[RUN_W-1:0];
      else members = value[MPG_W-1:0];
   endtask

   // wait for every report, then let adds and clears finish before a write
   task automatic drain_block();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (pending_reports.size() == 0);
      repeat (DRAIN) @(posedge clock);
   endtask

   // receiver stall pattern
   always @(negedge clock) begin
      case (idle_mode)
         IDLE_RECEIVER: rsp_stall <= ($urandom_range(99) < 72);
         IDLE_BOTH:     rsp_stall <= ($urandom_range(99) < 12);
         default:       rsp_stall <= 1'b0;
      endcase
   end

   // compare each report transfer with the oldest expected one
   always @(posedge clock) begin
      pmvs_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_reports.size() == 0) begin
            note_mismatch("unexpected rsp_valid", 64'd0, 64'd1);
         end else begin
            want = pending_reports.pop_front();
            if (rsp_data.group_index !== want.group_index)
               note_mismatch("group_index", want.group_index, rsp_data.group_index);
            if (rsp_data.member_index !== want.member_index)
               note_mismatch("member_index", want.member_index, rsp_data.member_index);
            if (rsp_data.mean_q16 !== want.mean_q16)
               note_mismatch("mean_q16", want.mean_q16, rsp_data.mean_q16);
            if (rsp_data.variance_q16 !== want.variance_q16)
               note_mismatch("variance_q16", want.variance_q16, rsp_data.variance_q16);
            if (rsp_data.stddev_q16 !== want.stddev_q16)
               note_mismatch("stddev_q16", want.stddev_q16, rsp_data.stddev_q16);
            if (rsp_data.cv_q16 !== want.cv_q16)
               note_mismatch("cv_q16", want.cv_q16, rsp_data.cv_q16);
            if (rsp_data.min_sample !== want.min_sample)
               note_mismatch("min_sample", want.min_sample, rsp_data.min_sample);
            if (rsp_data.max_sample !== want.max_sample)
               note_mismatch("max_sample", want.max_sample, rsp_data.max_sample);
         end
      end
   end

   function automatic stim_row_type row(input logic [1:0] kind, input int s, input int smp,
                                        input bit typed, input pmvs_rsp_type r);
      stim_row_type t;
      t.kind  = kind;
      t.slot  = s;
      t.smp   = smp;
      t.typed = typed;
      t.rsp   = r;
      return t;
   endfunction

   task automatic add_row(input stim_row_type t);
      directed.insert(directed.size(), t);
   endtask

   initial begin
      pmvs_rsp_type none;
      int run_set [8];
      int mpg_set [8];
      int hot [8];
      int pick, s, smp;
      logic [1:0] kind;

      run_set     = '{1, 1024, 0, 2047, 7, 3, 0, 1};
      mpg_set     = '{32, 1, 0, 63, 17, 33, 0, 5};
      none        = '0;
      idle_mode   = IDLE_NONE;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_wr_en   = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;
      run_count   = 1;
      members     = 32;
      for (int i = 0; i < SLOTS; i++) begin
         stat_sum[i] = '0;
         stat_sq[i]  = '0;
         stat_min[i] = '1;
         stat_max[i] = '0;
      end

      // directed table, reset register values (one run, 32 members)
      // empty slots right after reset
      add_row(row(REQ_REPORT, 0, 0, 1,
         '{10'd0, 5'd0, 40'd0, 63'd0, 39'd0, 22'd0, 24'hFF_FFFF, 24'd0}));
      add_row(row(REQ_REPORT, 1023, 0, 1,
         '{10'd31, 5'd31, 40'd0, 63'd0, 39'd0, 22'd0, 24'hFF_FFFF, 24'd0}));
      // largest sample, single run: no spread
      add_row(row(REQ_ADD, 1023, 24'hFF_FFFF, 0, none));
      add_row(row(REQ_REPORT, 1023, 0, 1,
         '{10'd31, 5'd31, 40'hFF_FFFF_0000, 63'd0, 39'd0, 22'd0, 24'hFF_FFFF,
           24'hFF_FFFF}));
      // zero sample: mean zero so cv is zero
      add_row(row(REQ_ADD, 5, 0, 0, none));
      add_row(row(REQ_REPORT, 5, 0, 1,
         '{10'd0, 5'd5, 40'd0, 63'd0, 39'd0, 22'd0, 24'd0, 24'd0}));
      // unknown request is dropped
      add_row(row(REQ_UNUSED, 5, 123, 0, none));
      // more samples than runs: variance numerator clamps at zero
      add_row(row(REQ_ADD, 5, 100, 0, none));
      add_row(row(REQ_ADD, 5, 300, 0, none));
      add_row(row(REQ_REPORT, 5, 0, 0, none));
      add_row(row(REQ_ADD, 37, 24'hAAAAAA, 0, none));
      add_row(row(REQ_ADD, 37, 24'h555555, 0, none));
      add_row(row(REQ_REPORT, 37, 0, 0, none));
      // clear puts the slot back to empty
      add_row(row(REQ_CLEAR, 5, 0, 0, none));
      add_row(row(REQ_REPORT, 5, 0, 1,
         '{10'd0, 5'd5, 40'd0, 63'd0, 39'd0, 22'd0, 24'hFF_FFFF, 24'd0}));
      add_row(row(REQ_CLEAR, 1023, 0, 0, none));

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed[i])
         send_request(directed[i].kind, directed[i].slot, directed[i].smp,
                      directed[i].typed, directed[i].rsp);
      drain_block();

      // random phases, about 900 transfers in all
      for (int p = 0; p < 8; p++) begin
         idle_mode = idle_mode_type'(p % 4);
         write_csr(CSR_RUN_COUNT, (p == 6) ? $urandom_range(2047) : run_set[p]);
         write_csr(CSR_MEMBERS, (p == 6) ? $urandom_range(63) : mpg_set[p]);
         foreach (hot[i]) hot[i] = $urandom_range(SLOTS - 1);

         for (int i = 0; i < 112; i++) begin
            pick = $urandom_range(99);
            kind = (pick < 70) ? REQ_ADD : (pick < 85) ? REQ_REPORT :
                   (pick < 95) ? REQ_CLEAR : REQ_UNUSED;
            s = ($urandom_range(9) == 0) ? $urandom_range(SLOTS - 1) : hot[$urandom_range(7)];
            case ($urandom_range(3))
               0:       smp = ($urandom_range(1) == 1) ? 24'hFF_FFFF : 0;
               1:       smp = $urandom_range(255);
               default: smp = $urandom_range(24'hFF_FFFF);
            endcase
            send_request(kind, s, smp, 0, none);
         end
         drain_block();
      end

      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ----- per_slot_mean_variance_stats.f -----
hdl/pmvs_pkg.sv
hdl/pmvs_store.sv
hdl/pmvs_div.sv
hdl/pmvs_mul.sv
hdl/pmvs_sqrt.sv
hdl/per_slot_mean_variance_stats.sv
tb/sv/testbench.sv
